@@ hw/rtl/smta_pkg.sv @@
`default_nettype none

package smta_pkg;

    // Term store geometry
    localparam int TERM_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(TERM_DEPTH);
    localparam int CNT_W      = $clog2(TERM_DEPTH + 1);
    localparam int EMIT_W     = 12;

    // Operation codes
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_PULL   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_TERM     = 3'd1;
    localparam logic [2:0] ST_END      = 3'd2;
    localparam logic [2:0] ST_INCOMPAT = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef struct packed {
        logic [15:0]        row;
        logic [15:0]        col;
        logic signed [15:0] value;
    } term_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;  // input word taken this cycle
        logic [1:0] op;      // its operation
        logic       cmp;     // merge compare cycle of a pull
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/smta_ctrl.sv @@
`default_nettype none

module smta_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    op,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire logic          dp_skip,
    output smta_pkg::cmd_t     cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       load_out;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign cmd.accept = accept;
    assign cmd.op     = op;
    assign cmd.cmp    = (state_reg == S_CMP);

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == smta_pkg::OP_PULL)
                        state_next = S_CMP;
                    else
                        load_out = 1'b1;
                end
            end
            S_CMP:
            begin
                if (dp_skip)
                    state_next = S_READ;
                else
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
                state_next = S_CMP;
            default:
                state_next = S_IDLE;
        endcase
        if (load_out)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smta_dpath.sv @@
`default_nettype none

module smta_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire smta_pkg::cmd_t      cmd,
    input  wire logic                dims_match,
    input  wire logic [15:0]         term_row,
    input  wire logic [15:0]         term_col,
    input  wire logic signed [15:0]  term_value,
    output logic                     dp_skip,
    output logic [2:0]               status,
    output logic [15:0]              out_row,
    output logic [15:0]              out_col,
    output logic signed [16:0]       out_value,
    output logic [11:0]              result_count
);

    localparam int AW = smta_pkg::ADDR_W;
    localparam int CW = smta_pkg::CNT_W;
    localparam int EW = smta_pkg::EMIT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(smta_pkg::TERM_DEPTH);

    smta_pkg::term_t a_mem [smta_pkg::TERM_DEPTH];
    smta_pkg::term_t b_mem [smta_pkg::TERM_DEPTH];
    smta_pkg::term_t a_rd_reg;
    smta_pkg::term_t b_rd_reg;
    smta_pkg::term_t wr_term;

    logic [CW-1:0] a_count_reg, a_count_next;
    logic [CW-1:0] b_count_reg, b_count_next;
    logic [CW-1:0] a_head_reg,  a_head_next;
    logic [CW-1:0] b_head_reg,  b_head_next;
    logic [EW-1:0] emitted_reg, emitted_next;
    logic [EW-1:0] emitted_inc;

    logic [2:0]         status_reg, status_next;
    logic [15:0]        row_reg,    row_next;
    logic [15:0]        col_reg,    col_next;
    logic signed [16:0] value_reg,  value_next;
    logic [EW-1:0]      count_reg,  count_next;

    logic               a_full, b_full, we_a, we_b;
    logic               a_ok, b_ok, pos_eq, a_first;
    logic signed [16:0] sum;

    assign wr_term.row   = term_row;
    assign wr_term.col   = term_col;
    assign wr_term.value = term_value;

    assign a_full = (a_count_reg == DEPTH_C);
    assign b_full = (b_count_reg == DEPTH_C);
    assign we_a   = cmd.accept && (cmd.op == smta_pkg::OP_LOAD_A) && !a_full;
    assign we_b   = cmd.accept && (cmd.op == smta_pkg::OP_LOAD_B) && !b_full;

    // Merge compare on the registered head terms
    assign a_ok    = a_head_reg < a_count_reg;
    assign b_ok    = b_head_reg < b_count_reg;
    assign pos_eq  = ({a_rd_reg.row, a_rd_reg.col} == {b_rd_reg.row, b_rd_reg.col});
    assign a_first = ({a_rd_reg.row, a_rd_reg.col} < {b_rd_reg.row, b_rd_reg.col});
    assign sum     = {a_rd_reg.value[15], a_rd_reg.value}
                   + {b_rd_reg.value[15], b_rd_reg.value};
    assign dp_skip = cmd.cmp && dims_match && a_ok && b_ok && pos_eq && (sum == 17'sd0);

    assign emitted_inc = (emitted_reg == {EW{1'b1}}) ? emitted_reg : emitted_reg + EW'(1);

    always_comb
    begin
        a_count_next = a_count_reg;
        b_count_next = b_count_reg;
        a_head_next  = a_head_reg;
        b_head_next  = b_head_reg;
        emitted_next = emitted_reg;
        status_next  = status_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        value_next   = value_reg;
        count_next   = count_reg;

        if (cmd.accept && (cmd.op != smta_pkg::OP_PULL))
        begin
            row_next    = '0;
            col_next    = '0;
            value_next  = '0;
            count_next  = emitted_reg;
            status_next = smta_pkg::ST_ACCEPTED;
            unique case (cmd.op)
                smta_pkg::OP_LOAD_A:
                begin
                    if (a_full)
                        status_next = smta_pkg::ST_FULL;
                    else
                        a_count_next = a_count_reg + CW'(1);
                end
                smta_pkg::OP_LOAD_B:
                begin
                    if (b_full)
                        status_next = smta_pkg::ST_FULL;
                    else
                        b_count_next = b_count_reg + CW'(1);
                end
                smta_pkg::OP_CLEAR:
                begin
                    a_count_next = '0;
                    b_count_next = '0;
                    a_head_next  = '0;
                    b_head_next  = '0;
                    emitted_next = '0;
                    count_next   = '0;
                end
                smta_pkg::OP_PULL:
                    status_next = smta_pkg::ST_ACCEPTED;
                default:
                    status_next = smta_pkg::ST_ACCEPTED;
            endcase
        end

        if (cmd.cmp && !dp_skip)
        begin
            row_next   = '0;
            col_next   = '0;
            value_next = '0;
            count_next = emitted_reg;
            if (!dims_match)
                status_next = smta_pkg::ST_INCOMPAT;
            else if (!a_ok && !b_ok)
                status_next = smta_pkg::ST_END;
            else
            begin
                status_next  = smta_pkg::ST_TERM;
                emitted_next = emitted_inc;
                count_next   = emitted_inc;
                if (a_ok && b_ok && pos_eq)
                begin
                    row_next    = a_rd_reg.row;
                    col_next    = a_rd_reg.col;
                    value_next  = sum;
                    a_head_next = a_head_reg + CW'(1);
                    b_head_next = b_head_reg + CW'(1);
                end
                else if (a_ok && (!b_ok || a_first))
                begin
                    row_next    = a_rd_reg.row;
                    col_next    = a_rd_reg.col;
                    value_next  = {a_rd_reg.value[15], a_rd_reg.value};
                    a_head_next = a_head_reg + CW'(1);
                end
                else
                begin
                    row_next    = b_rd_reg.row;
                    col_next    = b_rd_reg.col;
                    value_next  = {b_rd_reg.value[15], b_rd_reg.value};
                    b_head_next = b_head_reg + CW'(1);
                end
            end
        end
        else if (dp_skip)
        begin
            // drop a zero sum and retry on the next pair
            a_head_next = a_head_reg + CW'(1);
            b_head_next = b_head_reg + CW'(1);
        end
    end

    // Term stores: one write port, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (we_a)
            a_mem[a_count_reg[AW-1:0]] <= wr_term;
        a_rd_reg <= a_mem[a_head_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
            b_mem[b_count_reg[AW-1:0]] <= wr_term;
        b_rd_reg <= b_mem[b_head_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg <= '0;
            b_count_reg <= '0;
            a_head_reg  <= '0;
            b_head_reg  <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            a_count_reg <= a_count_next;
            b_count_reg <= b_count_next;
            a_head_reg  <= a_head_next;
            b_head_reg  <= b_head_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        value_reg  <= value_next;
        count_reg  <= count_next;
    end

    assign status       = status_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign out_value    = value_reg;
    assign result_count = count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sparse_matrix_triplet_add.sv @@
`default_nettype none

// Sparse matrix adder over (row, column, value) term lists. Each input word
// carries an op: load a term of A, load a term of B, pull the next term of
// A+B, or clear both stores, the merge heads and the result count. Every
// input word gives exactly one output word. A load or a clear is answered
// straight from the idle state; a pull first reads the head terms from the
// term RAMs, then does the compare/add; each equal-position pair whose sum
// is zero is skipped and needs a fresh RAM read at the new heads before the
// next compare. Each store holds 1024 terms; a load into a full store answers
// "store full". A pull with mismatched dimensions answers "incompatible"
// and leaves the merge where it is; once both lists are used up a pull
// answers "end" with the final count, which saturates at 4095. Load terms
// in row-major order. The dimension registers sit on the APB port at
// byte addresses 0, 4, 8, 12 (rows_a, cols_a, rows_b, cols_b); write them
// only while the block is idle. The output word is registered, so a new
// input word is taken in the same cycle that the previous result leaves.

module sparse_matrix_triplet_add (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          op,
    input  wire logic [15:0]         term_row,
    input  wire logic [15:0]         term_col,
    input  wire logic signed [15:0]  term_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               status,
    output logic [15:0]              out_row,
    output logic [15:0]              out_col,
    output logic signed [16:0]       out_value,
    output logic [11:0]              result_count,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    smta_pkg::cmd_t cmd;
    logic           dp_skip;
    logic           dims_match;
    logic           cfg_we;
    logic [1:0]     cfg_idx;

    logic [15:0] rows_a_reg, rows_a_next;
    logic [15:0] cols_a_reg, cols_a_next;
    logic [15:0] rows_b_reg, rows_b_next;
    logic [15:0] cols_b_reg, cols_b_next;

    // APB register file: pready is tied high, so accesses complete without wait states
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_we  = psel && penable && pwrite;

    always_comb
    begin
        rows_a_next = rows_a_reg;
        cols_a_next = cols_a_reg;
        rows_b_next = rows_b_reg;
        cols_b_next = cols_b_reg;
        prdata      = '0;
        unique case (cfg_idx)
            smta_pkg::REG_ROWS_A:
            begin
                prdata = {16'd0, rows_a_reg};
                if (cfg_we)
                    rows_a_next = pwdata[15:0];
            end
            smta_pkg::REG_COLS_A:
            begin
                prdata = {16'd0, cols_a_reg};
                if (cfg_we)
                    cols_a_next = pwdata[15:0];
            end
            smta_pkg::REG_ROWS_B:
            begin
                prdata = {16'd0, rows_b_reg};
                if (cfg_we)
                    rows_b_next = pwdata[15:0];
            end
            smta_pkg::REG_COLS_B:
            begin
                prdata = {16'd0, cols_b_reg};
                if (cfg_we)
                    cols_b_next = pwdata[15:0];
            end
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= '0;
            cols_a_reg <= '0;
            rows_b_reg <= '0;
            cols_b_reg <= '0;
        end
        else
        begin
            rows_a_reg <= rows_a_next;
            cols_a_reg <= cols_a_next;
            rows_b_reg <= rows_b_next;
            cols_b_reg <= cols_b_next;
        end
    end

    // A pull only merges when both shapes agree
    assign dims_match = (rows_a_reg == rows_b_reg) && (cols_a_reg == cols_b_reg);

    smta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_skip   (dp_skip),
        .cmd       (cmd)
    );

    smta_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dims_match   (dims_match),
        .term_row     (term_row),
        .term_col     (term_col),
        .term_value   (term_value),
        .dp_skip      (dp_skip),
        .status       (status),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .result_count (result_count)
    );

endmodule

`default_nettype wire
